// File: sv/kddp_pkg.sv
`timescale 1ns / 1ps

package kddp_pkg;

	// Default sizes handed to the top level as parameter defaults.
	localparam int KEY_MAX_CHARS_DEF       = 8;
	localparam int NUMBER_BUFFER_CHARS_DEF = 32;

	// The key register packs at most eight characters, so the window never needs more.
	localparam int KEY_WINDOW_MAX = 8;

	// Configuration port.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 64;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_CHARS  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH = 2'd1;

	// Characters the scanner reacts to.
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Magnitude limits of a signed 64-bit result, and the largest accumulator that
	// can take one more digit without a closer look at the digit itself.
	localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;
	localparam logic [63:0] ACC_SAFE  = 64'd922337203685477580;
	localparam logic [3:0]  POS_LAST_DIGIT = 4'd7;
	localparam logic [3:0]  NEG_LAST_DIGIT = 4'd8;

	// Scan phase of the current line.
	typedef enum logic [4:0] {
		PH_SEARCH     = 5'b00001,
		PH_AFTER_KEY  = 5'b00010,
		PH_AFTER_SIGN = 5'b00100,
		PH_DIGITS     = 5'b01000,
		PH_DONE       = 5'b10000
	} phase_t;

	// One input beat as it leaves the input register.
	typedef struct packed {
		logic [7:0] ch;
		logic       eol;
	} kddp_beat_t;

	// Configuration as seen by the scanner.
	typedef struct packed {
		logic [63:0] key_chars;
		logic [3:0]  key_length;
	} kddp_cfg_t;

	// Report for a finished line.
	typedef struct packed {
		logic        found;
		logic [63:0] value;
	} kddp_result_t;

endpackage

// File: sv/kddp_scan.sv
`timescale 1ns / 1ps

module kddp_scan import kddp_pkg::*; #(
	parameter int KEY_MAX_CHARS       = KEY_MAX_CHARS_DEF,
	parameter int NUMBER_BUFFER_CHARS = NUMBER_BUFFER_CHARS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  kddp_beat_t   beat,
	input  kddp_cfg_t    cfg,
	output kddp_result_t result
);

	localparam int KEY_CAP = (KEY_MAX_CHARS < KEY_WINDOW_MAX) ? KEY_MAX_CHARS : KEY_WINDOW_MAX;
	localparam int WIN_W   = 8 * KEY_CAP;
	localparam int FILL_W  = $clog2(KEY_CAP + 1);
	localparam int RUN_W   = $clog2(NUMBER_BUFFER_CHARS + 1);
	localparam logic [FILL_W-1:0] FILL_MAX  = FILL_W'(KEY_CAP);
	localparam logic [RUN_W-1:0]  RUN_MAX   = RUN_W'(NUMBER_BUFFER_CHARS);
	localparam logic [3:0]        KEY_CAP_L = 4'(KEY_CAP);

	logic [WIN_W-1:0]  window_q, window_d, window_next;
	logic [FILL_W-1:0] fill_q, fill_d, fill_next;
	phase_t            phase_q, phase_d;
	logic [RUN_W-1:0]  run_q, run_d, run_inc;
	logic [63:0]       acc_q, acc_d, acc_dig, acc_add, limit;
	logic              neg_q, neg_d, sat_q, sat_d, sat_dig;
	logic              is_digit, is_sign, ovf, hit;
	logic [3:0]        digit, klen;
	logic [2:0]        kidx;

	// Character classes; the low nibble of an ASCII digit is its value.
	assign is_digit = beat.ch inside {[CH_ZERO:CH_NINE]};
	assign is_sign  = (beat.ch == CH_PLUS) || (beat.ch == CH_MINUS);
	assign digit    = beat.ch[3:0];

	// Window and fill count after taking this character.
	assign window_next = (window_q << 8) | WIN_W'(beat.ch);
	assign fill_next   = (fill_q == FILL_MAX) ? fill_q : fill_q + 1'b1;
	assign run_inc     = (run_q < RUN_MAX) ? run_q + 1'b1 : run_q;

	// Effective key length, clamped to what the window holds.
	always_comb begin
		klen = cfg.key_length;
		if (klen == 4'd0) begin
			klen = 4'd1;
		end else if (klen > KEY_CAP_L) begin
			klen = KEY_CAP_L;
		end
	end

	// Key match: window byte i (newest first) against key byte klen-1-i.
	always_comb begin
		hit  = (4'(fill_next) >= klen);
		kidx = 3'd0;
		for (int i = 0; i < KEY_CAP; i++) begin
			kidx = 3'(klen - 4'(i) - 4'd1);
			if ((4'(i) < klen) && (window_next[8*i +: 8] != cfg.key_chars[{kidx, 3'b000} +: 8])) begin
				hit = 1'b0;
			end
		end
	end

	// Decimal accumulate with saturation at the signed 64-bit limits.
	assign limit   = neg_q ? NEG_LIMIT : POS_LIMIT;
	assign ovf     = (acc_q > ACC_SAFE) ||
	                 ((acc_q == ACC_SAFE) && (digit > (neg_q ? NEG_LAST_DIGIT : POS_LAST_DIGIT)));
	assign acc_add = (acc_q << 3) + (acc_q << 1) + 64'(digit);
	assign acc_dig = sat_q ? acc_q : (ovf ? limit : acc_add);
	assign sat_dig = sat_q | ovf;

	// Next state of the line scan.
	always_comb begin
		window_d = window_q;
		fill_d   = fill_q;
		phase_d  = phase_q;
		run_d    = run_q;
		acc_d    = acc_q;
		neg_d    = neg_q;
		sat_d    = sat_q;
		if (step) begin
			if (beat.eol) begin
				window_d = '0;
				fill_d   = '0;
				phase_d  = PH_SEARCH;
				run_d    = '0;
				acc_d    = '0;
				neg_d    = 1'b0;
				sat_d    = 1'b0;
			end else if (phase_q != PH_DONE) begin
				window_d = window_next;
				fill_d   = fill_next;
				case (phase_q)
					PH_AFTER_KEY: begin
						if (is_sign) begin
							neg_d   = (beat.ch == CH_MINUS);
							run_d   = run_inc;
							phase_d = PH_AFTER_SIGN;
						end else if (is_digit) begin
							run_d   = run_inc;
							acc_d   = acc_dig;
							sat_d   = sat_dig;
							phase_d = PH_DIGITS;
						end else begin
							phase_d = PH_SEARCH;
						end
					end
					PH_AFTER_SIGN: begin
						if (is_digit) begin
							run_d   = run_inc;
							acc_d   = acc_dig;
							sat_d   = sat_dig;
							phase_d = PH_DIGITS;
						end else begin
							phase_d = PH_SEARCH;
						end
					end
					PH_DIGITS: begin
						if (is_digit) begin
							run_d = run_inc;
							acc_d = acc_dig;
							sat_d = sat_dig;
						end else if (run_q < RUN_MAX) begin
							phase_d = PH_DONE;
						end else begin
							phase_d = PH_SEARCH;
						end
					end
					default: begin
					end
				endcase
				// A fresh key match starts a new candidate run.
				if ((phase_d == PH_SEARCH) && hit) begin
					phase_d = PH_AFTER_KEY;
					run_d   = '0;
					acc_d   = '0;
					neg_d   = 1'b0;
					sat_d   = 1'b0;
				end
			end
		end
	end

	// Scan state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			fill_q   <= '0;
			phase_q  <= PH_SEARCH;
			run_q    <= '0;
			acc_q    <= '0;
			neg_q    <= 1'b0;
			sat_q    <= 1'b0;
		end else begin
			window_q <= window_d;
			fill_q   <= fill_d;
			phase_q  <= phase_d;
			run_q    <= run_d;
			acc_q    <= acc_d;
			neg_q    <= neg_d;
			sat_q    <= sat_d;
		end
	end

	// Report for the line if it ended now; a run still open counts if short enough.
	always_comb begin
		result.found = (phase_q == PH_DONE) || ((phase_q == PH_DIGITS) && (run_q < RUN_MAX));
		result.value = '0;
		if (result.found) begin
			result.value = neg_q ? (64'd0 - acc_q) : acc_q;
		end
	end

	// The run length never passes its saturation point.
	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		run_q <= RUN_MAX)
		else $error("run length beyond buffer size");

	// A saturated accumulator holds exactly the limit for its sign.
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		sat_q |-> (acc_q == (neg_q ? NEG_LIMIT : POS_LIMIT)))
		else $error("saturated accumulator off its limit");

	// End of line leaves the scanner searching with an empty window.
	a_eol_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(step && beat.eol) |=> ((phase_q == PH_SEARCH) && (fill_q == '0) && !sat_q))
		else $error("line state not cleared at end of line");

endmodule

// File: sv/keyed_decimal_directive_parser.sv
`timescale 1ns / 1ps

// Scans a line one character per beat for a configured key of one to eight characters
// and reads the optionally signed decimal number right after it, saturating at the
// signed 64-bit limits. Only the first qualifying number counts; the end_of_line beat
// produces one result beat with found and value (value is 0 when nothing was found).
// The block takes one character every cycle: each character goes through an input
// register, then a scan step that shifts the key window, compares it and does the
// multiply-by-ten-and-add on the accumulator. A result is registered when its end_of_line
// beat leaves the input register; only an end_of_line beat that meets a full, stalled
// result register holds the input. Write key_chars and key_length between lines.
module keyed_decimal_directive_parser import kddp_pkg::*; #(
	parameter int KEY_MAX_CHARS       = KEY_MAX_CHARS_DEF,
	parameter int NUMBER_BUFFER_CHARS = NUMBER_BUFFER_CHARS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Character channel.
	input  logic                   item_valid,
	output logic                   item_stall,
	input  logic [7:0]             ch,
	input  logic                   end_of_line,
	// Result channel.
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic                   found,
	output logic signed [63:0]     value,
	// Configuration write channel.
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic         valid_s1;
	kddp_beat_t   beat_s1;
	logic         advance, accept, step;
	logic         result_valid_q;
	logic         found_q;
	logic [63:0]  value_q;
	logic [63:0]  key_chars_q;
	logic [3:0]   key_length_q;
	kddp_cfg_t    cfg;
	kddp_result_t line_result;

	// The input stage moves on unless an end of line meets a blocked result register.
	assign advance    = !beat_s1.eol || !result_valid_q || !result_stall;
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;
	assign step       = valid_s1 && advance;

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			beat_s1.ch  <= ch;
			beat_s1.eol <= end_of_line;
		end
	end

	// Configuration registers; the port is always ready.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_chars_q  <= '0;
			key_length_q <= 4'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_KEY_CHARS:  key_chars_q  <= cfg_data;
				REG_KEY_LENGTH: key_length_q <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg.key_chars  = key_chars_q;
	assign cfg.key_length = key_length_q;

	// Line scanner.
	kddp_scan #(
		.KEY_MAX_CHARS       (KEY_MAX_CHARS),
		.NUMBER_BUFFER_CHARS (NUMBER_BUFFER_CHARS)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.beat   (beat_s1),
		.cfg    (cfg),
		.result (line_result)
	);

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (step && beat_s1.eol) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (step && beat_s1.eol) begin
			found_q <= line_result.found;
			value_q <= line_result.value;
		end
	end

	assign result_valid = result_valid_q;
	assign found        = found_q;
	assign value        = $signed(value_q);

	// An end of line blocked by the result register stays in the input stage.
	a_eol_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && beat_s1.eol && result_valid_q && result_stall) |=> (valid_s1 && beat_s1.eol))
		else $error("blocked end of line lost");

	// A new result beat comes only from an end-of-line step.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(step && beat_s1.eol))
		else $error("result beat without end of line");

	// A line without a number reports zero.
	a_zero_when_absent: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && !found_q) |-> (value_q == 64'd0))
		else $error("nonzero value without a found number");

endmodule

// File: test/keyed_decimal_directive_parser_test.sv
`timescale 1ns / 1ps

module keyed_decimal_directive_parser_test;
	import kddp_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 200;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd2;

	typedef struct {
		bit        found;
		bit [63:0] value;
	} report_t;

	logic                   clk;
	logic                   arst_n;
	logic                   item_valid;
	logic                   item_stall;
	logic [7:0]             ch;
	logic                   end_of_line;
	logic                   result_valid;
	logic                   result_stall;
	logic                   found;
	logic signed [63:0]     value;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	keyed_decimal_directive_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.ch(ch),
		.end_of_line(end_of_line),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.found(found),
		.value(value),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Characters waiting to be sent, and reports the scanner should produce.
	kddp_beat_t  pending_chars[$];
	report_t     expected_reports[$];
	int unsigned queued_count;
	int unsigned taken_count;
	int unsigned lines_checked;
	int unsigned key_settings;
	int unsigned mismatches;
	int unsigned cycle_count;
	bit          char_taken;
	bit          send_busy;
	bit          recv_busy;
	int unsigned send_gap;
	int unsigned stall_left;
	int unsigned hold_left;
	bit          hold_request;

	// Predicted scanner state and configuration.
	bit [63:0]   model_key;
	bit [3:0]    model_key_len;
	bit [63:0]   model_window;
	int unsigned model_fill;
	phase_t      model_phase;
	int unsigned model_run;
	bit [63:0]   model_acc;
	bit          model_neg;
	bit          model_sat;
	bit          model_found;
	bit [63:0]   model_value;

	// Clock.
	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) cycle_count++;

	function automatic void clear_model_line();
		model_window = '0;
		model_fill = 0;
		model_phase = PH_SEARCH;
		model_run = 0;
		model_acc = '0;
		model_neg = 1'b0;
		model_sat = 1'b0;
		model_found = 1'b0;
		model_value = '0;
	endfunction

	// Number of key characters really compared: zero counts as one, above eight as eight.
	function automatic int unsigned key_span();
		int unsigned k;
		k = model_key_len;
		if (k < 1) k = 1;
		if (k > KEY_WINDOW_MAX) k = KEY_WINDOW_MAX;
		return k;
	endfunction

	// The newest character sits in the lowest window byte and must equal the last key byte.
	function automatic bit key_seen();
		int unsigned k;
		k = key_span();
		if (model_fill < k) return 1'b0;
		for (int i = 0; i < k; i++) begin
			if (model_window[8*i +: 8] != model_key[8*(k-1-i) +: 8]) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic bit is_digit(input bit [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	// Base-10 accumulation of the magnitude, pinned at the limit of the current sign.
	function automatic void take_digit(input bit [7:0] c);
		bit [63:0] d;
		bit [63:0] lim;
		d = c - CH_ZERO;
		lim = model_neg ? NEG_LIMIT : POS_LIMIT;
		if (model_run < NUMBER_BUFFER_CHARS_DEF) model_run++;
		if (model_sat) return;
		if (model_acc > (lim - d) / 10) begin
			model_acc = lim;
			model_sat = 1'b1;
		end else begin
			model_acc = model_acc * 10 + d;
		end
	endfunction

	// A run that fits the number buffer is accepted; a full one is dropped.
	function automatic void close_run();
		if (model_run < NUMBER_BUFFER_CHARS_DEF) begin
			model_found = 1'b1;
			model_value = model_neg ? 64'd0 - model_acc : model_acc;
			model_phase = PH_DONE;
		end else begin
			model_phase = PH_SEARCH;
		end
	endfunction

	// Advances the predicted scanner by one accepted beat.
	function automatic void scan_beat(input bit [7:0] c, input bit eol);
		report_t rep;
		if (eol) begin
			if (model_phase == PH_DIGITS) close_run();
			rep.found = model_found;
			rep.value = model_found ? model_value : 64'd0;
			expected_reports.push_back(rep);
			clear_model_line();
			return;
		end
		if (model_phase == PH_DONE) return;
		model_window = {model_window[55:0], c};
		if (model_fill < KEY_WINDOW_MAX) model_fill++;
		case (model_phase)
			PH_AFTER_KEY: begin
				if (c == CH_PLUS || c == CH_MINUS) begin
					model_neg = (c == CH_MINUS);
					if (model_run < NUMBER_BUFFER_CHARS_DEF) model_run++;
					model_phase = PH_AFTER_SIGN;
				end else if (is_digit(c)) begin
					take_digit(c);
					model_phase = PH_DIGITS;
				end else begin
					model_phase = PH_SEARCH;
				end
			end
			PH_AFTER_SIGN: begin
				if (is_digit(c)) begin
					take_digit(c);
					model_phase = PH_DIGITS;
				end else begin
					model_phase = PH_SEARCH;
				end
			end
			PH_DIGITS: begin
				if (is_digit(c)) take_digit(c);
				else close_run();
			end
			default: begin
			end
		endcase
		// The character that ends a run can still complete a new key.
		if (model_phase == PH_SEARCH && key_seen()) begin
			model_phase = PH_AFTER_KEY;
			model_run = 0;
			model_acc = '0;
			model_neg = 1'b0;
			model_sat = 1'b0;
		end
	endfunction

	task automatic flag_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		mismatches++;
	endtask

	// Idle lengths: mostly none or short, now and then a long one.
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Character driver.
	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || char_taken) begin
			if (send_gap != 0) begin
				send_gap--;
				item_valid <= 1'b0;
			end else if (pending_chars.size() != 0) begin
				kddp_beat_t beat;
				beat = pending_chars.pop_front();
				ch <= beat.ch;
				end_of_line <= beat.eol;
				item_valid <= 1'b1;
				send_gap = send_busy ? idle_len() : 0;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls plus the long hold-off.
	always @(negedge clk) begin
		if (stall_left == 0 && recv_busy && $urandom_range(0, 3) == 0) stall_left = idle_len();
		result_stall <= (stall_left != 0) || (hold_left != 0);
		if (stall_left != 0) stall_left--;
	end

	always @(posedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
		end
	end

	// Monitor: predicts on every accepted character, checks every accepted report.
	always @(posedge clk) begin : result_check
		report_t want;
		char_taken = arst_n && item_valid && !item_stall;
		if (char_taken) begin
			scan_beat(ch, end_of_line);
			taken_count++;
		end
		if (arst_n && result_valid && !result_stall) begin
			lines_checked++;
			if (expected_reports.size() == 0) begin
				flag_mismatch("report beat with no line pending");
			end else begin
				want = expected_reports.pop_front();
				if (found !== want.found)
					flag_mismatch($sformatf("found %b, predicted %b", found, want.found));
				if (value !== want.value)
					flag_mismatch($sformatf("value %0d, predicted %0d", value,
						$signed(want.value)));
			end
		end
	end

	function automatic bit [63:0] pack_key(input string s);
		bit [63:0] k;
		k = '0;
		for (int i = 0; i < s.len() && i < 8; i++) k[8*i +: 8] = s[i];
		return k;
	endfunction

	function automatic void queue_byte(input bit [7:0] c);
		kddp_beat_t beat;
		beat.ch = c;
		beat.eol = 1'b0;
		pending_chars.push_back(beat);
		queued_count++;
	endfunction

	// The terminator carries a random character, which must be ignored.
	function automatic void queue_eol();
		kddp_beat_t beat;
		beat.ch = 8'($urandom_range(0, 255));
		beat.eol = 1'b1;
		pending_chars.push_back(beat);
		queued_count++;
	endfunction

	function automatic void queue_text(input string s);
		for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
	endfunction

	function automatic void queue_key(input int unsigned count);
		for (int i = 0; i < count; i++) queue_byte(model_key[8*i +: 8]);
	endfunction

	function automatic void queue_digits(input int unsigned count);
		repeat (count) queue_byte(CH_ZERO + 8'($urandom_range(0, 9)));
	endfunction

	function automatic bit [7:0] noise_char();
		int unsigned r;
		int unsigned b;
		r = $urandom_range(0, 7);
		b = $urandom_range(0, key_span() - 1);
		case (r)
			0, 1: return CH_ZERO + 8'($urandom_range(0, 9));
			2: return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
			3: return model_key[8*b +: 8];
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Magnitudes at and around the signed 64-bit limits.
	function automatic bit [63:0] edge_magnitude();
		case ($urandom_range(0, 5))
			0: return POS_LIMIT;
			1: return NEG_LIMIT;
			2: return POS_LIMIT - 1;
			3: return NEG_LIMIT + 1;
			4: return 64'hFFFF_FFFF_FFFF_FFFF;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Mostly keyed numbers with random content, the rest broken keys and noise.
	task automatic queue_random_lines(input int unsigned goal, input bit short_lines);
		int unsigned kind;
		string digits;
		while (queued_count < goal) begin
			kind = $urandom_range(0, 99);
			repeat ($urandom_range(0, short_lines ? 1 : 4)) queue_byte(noise_char());
			if ($urandom_range(0, 4) == 0) queue_key($urandom_range(0, key_span() - 1));
			if (kind < 75) begin
				queue_key(key_span());
				case ($urandom_range(0, 3))
					0: queue_byte(CH_PLUS);
					1: queue_byte(CH_MINUS);
					default: begin
					end
				endcase
				case ($urandom_range(0, 9))
					0: begin
						digits = $sformatf("%0d", edge_magnitude());
						queue_text(digits);
					end
					1: queue_digits($urandom_range(29, 32));
					2: queue_digits($urandom_range(17, 21));
					default: queue_digits($urandom_range(1, 5));
				endcase
				// Later keyed numbers on the line are ignored once one is accepted.
				if ($urandom_range(0, 2) == 0) begin
					queue_byte(noise_char());
					queue_key(key_span());
					queue_digits($urandom_range(1, 3));
				end
				repeat ($urandom_range(0, short_lines ? 0 : 3)) queue_byte(noise_char());
			end else if (kind < 90) begin
				queue_key(key_span());
				if ($urandom_range(0, 1)) queue_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
				queue_byte(noise_char());
			end else begin
				repeat ($urandom_range(1, 12)) queue_byte(8'($urandom_range(0, 255)));
			end
			queue_eol();
		end
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_KEY_CHARS) model_key = data;
		else if (idx == REG_KEY_LENGTH) model_key_len = data[3:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_key(input logic [63:0] chars, input logic [63:0] len);
		write_reg(REG_KEY_CHARS, chars);
		write_reg(REG_KEY_LENGTH, len);
		key_settings++;
	endtask

	// Waits until every character is taken and every report has come back.
	task automatic drain();
		while (taken_count != queued_count || expected_reports.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_idling(input bit s, input bit r);
		send_busy = s;
		recv_busy = r;
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		ch = '0;
		end_of_line = 1'b0;
		result_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_request = 1'b0;
		model_key = '0;
		model_key_len = 4'd1;
		key_settings = 1;
		clear_model_line();
		set_idling(1'b1, 1'b1);
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset configuration: the key is a single zero byte.
		queue_byte(8'h00);
		queue_text("42");
		queue_eol();
		queue_random_lines(170, 1'b0);
		drain();

		// Directed lines on a one-character key.
		set_key(pack_key("="), 64'd1);
		set_idling(1'b0, 1'b0);
		queue_text("=+7");
		queue_eol();
		queue_text("=-0");
		queue_eol();
		queue_text("=-x");
		queue_eol();
		queue_byte("=");
		queue_eol();
		queue_eol();
		queue_byte(8'hFF);
		queue_byte(8'h00);
		queue_text("=5=6");
		queue_eol();
		queue_text("=+=3");
		queue_eol();
		set_idling(1'b1, 1'b1);
		queue_random_lines(340, 1'b0);
		drain();

		// Longer keys, with no idling on either side for a stretch.
		set_key(pack_key("SPEED:"), 64'd6);
		set_idling(1'b0, 1'b0);
		queue_random_lines(510, 1'b0);
		drain();

		set_key(pack_key("maxdepth"), 64'd8);
		set_idling(1'b1, 1'b0);
		queue_random_lines(680, 1'b0);
		drain();

		// A key ending in a digit, so key matches fall inside runs.
		set_key(pack_key("v2"), 64'd2);
		set_idling(1'b0, 1'b1);
		queue_random_lines(850, 1'b0);
		drain();

		// Length zero acts as one, length fifteen as eight.
		set_key(pack_key("#tag"), 64'd0);
		set_idling(1'b1, 1'b1);
		queue_random_lines(1000, 1'b0);
		drain();

		set_key(pack_key("@limit=!"), 64'd15);
		queue_random_lines(1150, 1'b0);
		drain();

		set_key(64'hFFFF_FFFF_FFFF_FFFF, 64'd3);
		queue_random_lines(1300, 1'b0);
		drain();

		// An unused register index must leave the key alone; then a random key under
		// a long receiver hold-off while short lines keep coming.
		write_reg(REG_UNUSED, {$urandom, $urandom});
		set_key({$urandom, $urandom}, 64'($urandom_range(1, 8)));
		set_idling(1'b0, 1'b1);
		@(negedge clk);
		hold_request = 1'b1;
		queue_random_lines(1520, 1'b1);
		drain();

		repeat (10) @(posedge clk);
		$display("Covered %0d characters in %0d checked lines over %0d key settings.",
			taken_count, lines_checked, key_settings);
		$display("Mismatches found: %0d.", mismatches);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		cycle_count = 0;
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timed out after %0d cycles with %0d reports outstanding.",
			cycle_count, expected_reports.size());
		$display("FAILURE");
		$finish;
	end

endmodule

// File: keyed_decimal_directive_parser.f
sv/kddp_pkg.sv
sv/kddp_scan.sv
sv/keyed_decimal_directive_parser.sv
test/keyed_decimal_directive_parser_test.sv
